[design/kslp_pkg.sv]
// Package: shared types and constants for the short/long key press detector.
package kslp_pkg;

  localparam int NUM_KEYS  = 7;
  localparam int KEYS_W    = 7;
  localparam int CODE_W    = 3;
  localparam int TIMER_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG      = 2'd2;

  // Register reset values
  localparam logic [TIMER_W-1:0] SHORT_MIN_RST = 8'd1;
  localparam logic [TIMER_W-1:0] SHORT_MAX_RST = 8'd6;
  localparam logic [TIMER_W-1:0] LONG_RST      = 8'd8;

  typedef struct packed {
    logic [TIMER_W-1:0] short_min_ticks;
    logic [TIMER_W-1:0] short_max_ticks;
    logic [TIMER_W-1:0] long_ticks;
  } cfg_t;

endpackage

[design/kslp_intf.sv]
// Interfaces: item, result and configuration channels.
interface kslp_item_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [kslp_pkg::KEYS_W-1:0] keys_n;

  modport source (output valid, kind, keys_n, input ready);
  modport sink (input valid, kind, keys_n, output ready);
endinterface

interface kslp_result_if;
  logic                        valid;
  logic                        ready;
  logic [kslp_pkg::CODE_W-1:0] key_code;
  logic                        long_press;

  modport source (output valid, key_code, long_press, input ready);
  modport sink (input valid, key_code, long_press, output ready);
endinterface

interface kslp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kslp_pkg::CFG_IDX_W-1:0] index;
  logic [kslp_pkg::TIMER_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/kslp_cfg_regs.sv]
// Configuration registers: press window bounds and long press threshold.
module kslp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [kslp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [kslp_pkg::TIMER_W-1:0]   wr_data,
  output kslp_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_min_ticks <= kslp_pkg::SHORT_MIN_RST;
      cfg.short_max_ticks <= kslp_pkg::SHORT_MAX_RST;
      cfg.long_ticks      <= kslp_pkg::LONG_RST;
    end else if (wr_en) begin
      case (wr_index)
        kslp_pkg::REG_SHORT_MIN: cfg.short_min_ticks <= wr_data;
        kslp_pkg::REG_SHORT_MAX: cfg.short_max_ticks <= wr_data;
        kslp_pkg::REG_LONG:      cfg.long_ticks      <= wr_data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

[design/kslp_core.sv]
// Press tracking state and short/long classification for one item per cycle while go is high.
module kslp_core #(
  parameter int NUM_KEYS = kslp_pkg::NUM_KEYS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic                        kind,
  input  logic [kslp_pkg::KEYS_W-1:0] keys_n,
  input  kslp_pkg::cfg_t              cfg,
  output logic                        res_valid,
  output logic [kslp_pkg::CODE_W-1:0] res_code,
  output logic                        res_long
);

  logic                         tracking, tracking_next;
  logic [kslp_pkg::CODE_W-1:0]  held_key, held_key_next;
  logic [kslp_pkg::TIMER_W-1:0] press_timer, press_timer_next;
  logic                         timer_running, timer_running_next;
  logic [kslp_pkg::CODE_W-1:0]  code;

  // Lowest pressed key wins; keys at or above NUM_KEYS are ignored.
  always_comb begin
    code = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (!keys_n[i]) begin
        code = kslp_pkg::CODE_W'(i + 1);
      end
    end
  end

  always_comb begin
    tracking_next      = tracking;
    held_key_next      = held_key;
    press_timer_next   = press_timer;
    timer_running_next = timer_running;
    res_valid          = 1'b0;
    res_code           = held_key;
    res_long           = 1'b0;
    if (kind == kslp_pkg::KIND_TICK) begin
      if (timer_running && press_timer != kslp_pkg::TIMER_MAX) begin
        press_timer_next = press_timer + 1'b1;
      end
    end else if (code == '0) begin
      // Full release: report a short press inside the open window.
      res_valid = (press_timer > cfg.short_min_ticks) &&
                  (press_timer < cfg.short_max_ticks) && (held_key != '0);
      tracking_next      = 1'b0;
      timer_running_next = 1'b0;
      press_timer_next   = '0;
    end else if (!tracking) begin
      held_key_next    = code;
      tracking_next    = 1'b1;
      press_timer_next = '0;
    end else if (code == held_key) begin
      timer_running_next = 1'b1;
      if (press_timer > cfg.long_ticks) begin
        press_timer_next = cfg.long_ticks;
        res_valid        = 1'b1;
        res_long         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking      <= 1'b0;
      held_key      <= '0;
      press_timer   <= '0;
      timer_running <= 1'b0;
    end else if (go) begin
      tracking      <= tracking_next;
      held_key      <= held_key_next;
      press_timer   <= press_timer_next;
      timer_running <= timer_running_next;
    end
  end

  a_run_needs_track: assert property (@(posedge clk) disable iff (rst)
    timer_running |-> tracking)
    else $error("timer running while no key is tracked");

  a_timer_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (press_timer != '0) |-> tracking)
    else $error("press timer nonzero while idle");

  a_long_from_track: assert property (@(posedge clk) disable iff (rst)
    (go && res_valid && res_long) |=> (press_timer == $past(cfg.long_ticks)) && tracking)
    else $error("long press did not clamp the timer");

  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    (kind == kslp_pkg::KIND_TICK) |-> !res_valid)
    else $error("tick produced a result");

endmodule

[design/key_short_long_press_detector_top.sv]
// An item transferred into the input register gives its result at the output register
//   on the edge where the input stage advances; a stalled result side delays that edge.
// Throughput: one item per cycle while the result side takes each transfer.
// The tracking state is registered feedback updated on each advance, so every item sees the last.
// Reset (rst, synchronous, active high) clears tracking state and both stages
//   and loads the window registers with 1, 6 and 8.
module key_short_long_press_detector_top #(
  parameter int NUM_KEYS = kslp_pkg::NUM_KEYS
) (
  input logic          clk,
  input logic          rst,
  kslp_item_if.sink    items,
  kslp_result_if.source results,
  kslp_cfg_if.sink     cfg
);

  // Input stage: hold one item until the result register can take its outcome.
  logic                        s1_valid;
  logic                        s1_kind;
  logic [kslp_pkg::KEYS_W-1:0] s1_keys_n;
  logic                        s1_go;

  // Result stage.
  logic                        out_valid;
  logic [kslp_pkg::CODE_W-1:0] out_code;
  logic                        out_long;

  // Core outcome for the item in the input stage.
  logic                        res_valid;
  logic [kslp_pkg::CODE_W-1:0] res_code;
  logic                        res_long;

  kslp_pkg::cfg_t              cfg_regs;

  // The input stage advances when the result register is empty or draining,
  // so a stalled result never loses the next outcome.
  assign s1_go       = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || s1_go;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  // Payload needs no reset; capture on every input transfer.
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_kind   <= items.kind;
      s1_keys_n <= items.keys_n;
    end
  end

  kslp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  kslp_core #(
    .NUM_KEYS (NUM_KEYS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (s1_go),
    .kind      (s1_kind),
    .keys_n    (s1_keys_n),
    .cfg       (cfg_regs),
    .res_valid (res_valid),
    .res_code  (res_code),
    .res_long  (res_long)
  );

  // Result register: load on advance, drop after the transfer otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= res_valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_code <= res_code;
      out_long <= res_long;
    end
  end

  assign results.valid      = out_valid;
  assign results.key_code   = out_code;
  assign results.long_press = out_long;

endmodule
